/* design/lbf_pkg.sv */
// Shared types and constants of the load block framer.
package lbf_pkg;

    // One bit per kind of output byte, in the order the bytes leave the block.
    localparam int KIND_W = 10;
    localparam int K_SIG  = 0;
    localparam int K_LEN  = 1;
    localparam int K_ALO  = 2;
    localparam int K_AHI  = 3;
    localparam int K_DATA = 4;
    localparam int K_SUM  = 5;
    localparam int K_MRK1 = 6;
    localparam int K_MRK2 = 7;
    localparam int K_SLO  = 8;
    localparam int K_SHI  = 9;

    localparam logic [7:0] SIG_CMD   = 8'h01;
    localparam logic [7:0] SIG_TAPE  = 8'h3C;
    localparam logic [7:0] MARK_CMD  = 8'h02;
    localparam logic [7:0] MARK_TAPE = 8'h78;

    localparam logic [8:0]  BS_MIN       = 9'd10;
    localparam logic [8:0]  BS_MAX       = 9'd256;
    localparam logic [8:0]  CMD_OVERHEAD = 9'd2;
    localparam logic [7:0]  CMD_LEN_ADD  = 8'd2;
    localparam logic [16:0] TOTAL_MAX    = 17'd65536;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CFG_CMD_FORMAT   = 2'd0,
        CFG_BLOCK_SIZE   = 2'd1,
        CFG_LOAD_ADDRESS = 2'd2,
        CFG_TOTAL_LENGTH = 2'd3
    } cfg_index_t;

    // Everything the back end needs to emit the bytes caused by one program byte.
    typedef struct packed {
        logic [KIND_W-1:0] kinds;
        logic              cmd;
        logic [7:0]        len;
        logic [15:0]       addr;
        logic [7:0]        data;
        logic [7:0]        sum;
        logic [15:0]       start_addr;
    } job_t;

endpackage

/* design/lbf_front.sv */
// Front end: configuration registers, file position tracking and job building.
module lbf_front
    import lbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        push,
    input  logic [7:0]  data_byte,
    input  logic        q_full,
    output logic        q_wr,
    output job_t        q_job
);

    logic        cmd_reg;
    logic [8:0]  block_size_reg;
    logic [15:0] load_address_reg;
    logic [16:0] total_length_reg;

    logic [15:0] byte_index_reg, byte_index_next;
    logic [8:0]  block_fill_reg, block_fill_next;
    logic [7:0]  running_sum_reg, running_sum_next;

    logic [8:0]  bs;
    logic [8:0]  eff;
    logic [16:0] total;
    logic [16:0] idx_ext;
    logic        last;
    logic        hdr;
    logic [15:0] addr;
    logic [16:0] remaining;
    logic        partial;
    logic [7:0]  len;
    logic [7:0]  sum_base;
    logic [7:0]  sum_new;
    logic [8:0]  fill_inc;
    logic        closed;
    logic        accept;

    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg          <= 1'b0;
            block_size_reg   <= BS_MAX;
            load_address_reg <= '0;
            total_length_reg <= 17'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CMD_FORMAT:   cmd_reg          <= cfg_data[0];
                CFG_BLOCK_SIZE:   block_size_reg   <= cfg_data[8:0];
                CFG_LOAD_ADDRESS: load_address_reg <= cfg_data[15:0];
                CFG_TOTAL_LENGTH: total_length_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        if (block_size_reg < BS_MIN)
            bs = BS_MIN;
        else if (block_size_reg > BS_MAX)
            bs = BS_MAX;
        else
            bs = block_size_reg;

        if (total_length_reg == 17'd0)
            total = 17'd1;
        else if (total_length_reg > TOTAL_MAX)
            total = TOTAL_MAX;
        else
            total = total_length_reg;

        eff     = cmd_reg ? (bs - CMD_OVERHEAD) : bs;
        idx_ext = {1'b0, byte_index_reg};
        last    = (idx_ext + 17'd1) >= total;
        hdr     = (block_fill_reg == 9'd0);
        addr    = load_address_reg + byte_index_reg;

        remaining = (total > idx_ext) ? (total - idx_ext) : 17'd1;
        partial   = remaining < {8'b0, eff};
        // A partial block is shorter than 256, so its count fits in one byte.
        if (partial)
            len = cmd_reg ? (remaining[7:0] + CMD_LEN_ADD) : remaining[7:0];
        else
            len = bs[7:0];

        sum_base = hdr ? (addr[7:0] + addr[15:8]) : running_sum_reg;
        sum_new  = sum_base + data_byte;
        fill_inc = block_fill_reg + 9'd1;
        closed   = fill_inc >= eff;

        q_job.kinds          = '0;
        q_job.kinds[K_SIG]   = hdr;
        q_job.kinds[K_LEN]   = hdr;
        q_job.kinds[K_ALO]   = hdr;
        q_job.kinds[K_AHI]   = hdr;
        q_job.kinds[K_DATA]  = 1'b1;
        // In tape mode a checksum follows a closed block, or the open one at end of file.
        q_job.kinds[K_SUM]   = !cmd_reg && (closed || last);
        q_job.kinds[K_MRK1]  = last;
        q_job.kinds[K_MRK2]  = last && cmd_reg;
        q_job.kinds[K_SLO]   = last;
        q_job.kinds[K_SHI]   = last;
        q_job.cmd            = cmd_reg;
        q_job.len            = len;
        q_job.addr           = addr;
        q_job.data           = data_byte;
        q_job.sum            = sum_new;
        q_job.start_addr     = load_address_reg;
        q_wr                 = accept;

        if (last)
        begin
            byte_index_next  = '0;
            block_fill_next  = '0;
            running_sum_next = '0;
        end
        else
        begin
            byte_index_next  = byte_index_reg + 16'd1;
            block_fill_next  = closed ? 9'd0 : fill_inc;
            running_sum_next = sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= '0;
            block_fill_reg  <= '0;
            running_sum_reg <= '0;
        end
        else if (accept)
        begin
            byte_index_reg  <= byte_index_next;
            block_fill_reg  <= block_fill_next;
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

/* design/lbf_queue.sv */
// Short job queue between the front end and the byte emitter.
module lbf_queue
    import lbf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  job_t wr_job,
    output logic full,
    input  logic rd,
    output logic head_valid,
    output job_t head_job
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_wr, do_rd;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_wr      = wr && !full;
    assign do_rd      = rd && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

/* design/lbf_back.sv */
// Back end: walks the byte kinds of each job and feeds the output register.
module lbf_back
    import lbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  job_t       q_head,
    output logic       q_rd,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       file_done
);

    job_t              cur_job_reg, cur_job_next;
    logic [KIND_W-1:0] mask_reg, mask_next;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              run_last_reg;
    logic              file_done_reg;

    logic              load_ok;
    logic              active;
    logic              emit;
    logic [KIND_W-1:0] low;
    logic [KIND_W-1:0] mask_rest;
    logic              take;
    logic [7:0]        sel_byte;

    assign load_ok   = !out_valid_reg || pop;
    assign active    = (mask_reg != '0);
    assign emit      = active && load_ok;
    assign low       = mask_reg & (~mask_reg + KIND_W'(1));
    assign mask_rest = mask_reg & ~low;
    // The next job moves in when the current one is gone or leaves its final beat now.
    assign take      = q_valid && (!active || (emit && (mask_rest == '0)));
    assign q_rd      = take;

    always_comb
    begin
        priority case (1'b1)
            mask_reg[K_SIG]:  sel_byte = cur_job_reg.cmd ? SIG_CMD : SIG_TAPE;
            mask_reg[K_LEN]:  sel_byte = cur_job_reg.len;
            mask_reg[K_ALO]:  sel_byte = cur_job_reg.addr[7:0];
            mask_reg[K_AHI]:  sel_byte = cur_job_reg.addr[15:8];
            mask_reg[K_DATA]: sel_byte = cur_job_reg.data;
            mask_reg[K_SUM]:  sel_byte = cur_job_reg.sum;
            mask_reg[K_MRK1]: sel_byte = cur_job_reg.cmd ? MARK_CMD : MARK_TAPE;
            mask_reg[K_MRK2]: sel_byte = MARK_CMD;
            mask_reg[K_SLO]:  sel_byte = cur_job_reg.start_addr[7:0];
            default:          sel_byte = cur_job_reg.start_addr[15:8];
        endcase

        mask_next    = mask_reg;
        cur_job_next = cur_job_reg;
        if (take)
        begin
            mask_next    = q_head.kinds;
            cur_job_next = q_head;
        end
        else if (emit)
        begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_job_reg <= cur_job_next;
        if (emit)
        begin
            out_byte_reg  <= sel_byte;
            run_last_reg  <= (mask_rest == '0);
            file_done_reg <= low[K_SHI];
        end
    end

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign file_done = file_done_reg;

endmodule

/* design/load_block_framer_top.sv */
// Load block framer: an item taken by an idle block goes through the job queue and the
// job register of the byte emitter into the output register. An item causes 1 to 9 result
// beats; the byte emitter sends one beat per cycle while the output is popped. Items are taken
// one per cycle while the 4-job queue has room, so the sustained rate is set by the emitter:
// one item per cycle on data-only stretches, less where header, checksum or trailer beats come.
// Reset (asynchronous, active low) empties the queue and output register, sets the registers
// to tape mode, block size 256, address 0, length 1, and starts a new file.
module load_block_framer_top
    import lbf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        file_done
);

    logic q_wr;
    job_t q_wr_job;
    logic q_full;
    logic q_rd;
    logic q_valid;
    job_t q_head;

    assign full = q_full;

    lbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_job     (q_wr_job)
    );

    lbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (q_wr),
        .wr_job     (q_wr_job),
        .full       (q_full),
        .rd         (q_rd),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    lbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .file_done (file_done)
    );

endmodule

/* design/lbf_checker.sv */
// Port-level checks of the load block framer and their binding to the top level.
module lbf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       file_done,
    input logic       cfg_ready
);

    // The final trailer byte always closes the run of beats of its item.
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && file_done |-> run_last)
        else $error("file_done beat without run_last");

    // Beats of one item follow each other with no gap once the first one is taken.
    a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !run_last |=> !empty)
        else $error("gap inside a run of result beats");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_byte) && $stable(run_last)
            && $stable(file_done))
        else $error("waiting result beat changed");

    // Configuration writes are never stalled.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind load_block_framer_top lbf_checker u_lbf_checker (.*);

/* verif/load_block_framer_top_tb.sv */
// Self-checking testbench for the load block framer: framed bytes are checked beat by beat.
module load_block_framer_top_tb;
    import lbf_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       done;
    } framed_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_CMD_FORMAT;
    logic [16:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        file_done;

    load_block_framer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .file_done (file_done)
    );

    // Register copies and framing state of the predictor.
    logic        fmt_cmd = 1'b0;
    logic [8:0]  blk_size = 9'd256;
    logic [15:0] base_addr = '0;
    logic [16:0] file_len = 17'd1;
    logic [15:0] byte_pos = '0;
    logic [8:0]  fill = '0;
    logic [7:0]  csum = '0;
    logic        csum_open = 1'b0;

    logic [7:0]   program_bytes[$];
    framed_beat_t framed_due[$];

    int mismatches = 0;
    int items_sent = 0;
    int send_idle_pct = 11;
    int recv_idle_pct = 71;
    bit stall_armed = 1'b0;
    bit stall_taken = 1'b0;
    int stall_left = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400000);
        $display("load_block_framer_top verification failed");
        $finish;
    end

    task automatic put_beat(input logic [7:0] value, input logic done);
        framed_beat_t beat;
        beat.value = value;
        beat.last = 1'b0;
        beat.done = done;
        framed_due.push_back(beat);
    endtask

    // Appends the framed bytes that one program byte causes.
    task automatic frame_byte(input logic [7:0] d);
        int          span;
        int          total;
        int          room;
        int          rest;
        logic [15:0] addr;
        logic        closing;
        span = (blk_size < BS_MIN) ? int'(BS_MIN) :
               (blk_size > BS_MAX) ? int'(BS_MAX) : int'(blk_size);
        total = (file_len == 0) ? 1 : (file_len > TOTAL_MAX) ? int'(TOTAL_MAX) : int'(file_len);
        room = fmt_cmd ? span - int'(CMD_OVERHEAD) : span;
        closing = (int'(byte_pos) + 1 >= total);

        if (fill == 0)
        begin
            addr = base_addr + byte_pos;
            rest = (total > int'(byte_pos)) ? total - int'(byte_pos) : 1;
            put_beat(fmt_cmd ? SIG_CMD : SIG_TAPE, 1'b0);
            // A full block writes its size, so 256 comes out as zero.
            if (rest < room)
                put_beat(8'(fmt_cmd ? rest + int'(CMD_LEN_ADD) : rest), 1'b0);
            else
                put_beat(8'(span), 1'b0);
            put_beat(addr[7:0], 1'b0);
            put_beat(addr[15:8], 1'b0);
            csum = addr[7:0] + addr[15:8];
        end

        csum = csum + d;
        put_beat(d, 1'b0);
        csum_open = 1'b1;
        fill = fill + 9'd1;
        if (int'(fill) >= room)
        begin
            fill = '0;
            if (!fmt_cmd)
            begin
                put_beat(csum, 1'b0);
                csum_open = 1'b0;
            end
        end

        if (closing)
        begin
            if (fmt_cmd)
            begin
                put_beat(MARK_CMD, 1'b0);
                put_beat(MARK_CMD, 1'b0);
            end
            else
            begin
                if (csum_open)
                    put_beat(csum, 1'b0);
                put_beat(MARK_TAPE, 1'b0);
            end
            put_beat(base_addr[7:0], 1'b0);
            put_beat(base_addr[15:8], 1'b1);
            byte_pos = '0;
            fill = '0;
            csum = '0;
            csum_open = 1'b0;
        end
        else
        begin
            byte_pos = byte_pos + 16'd1;
        end

        framed_due[framed_due.size() - 1].last = 1'b1;
    endtask

    // Sender: offers the oldest pending program byte, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic offer;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                frame_byte(data_byte);
                void'(program_bytes.pop_front());
            end
            offer = (program_bytes.size() > 0) && ($urandom_range(99) >= send_idle_pct);
            push <= offer;
            if (offer)
                data_byte <= program_bytes[0];
        end
    end

    // Receiver: pops beats at random and checks each against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        framed_beat_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (framed_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected beat out_byte=%h run_last=%b file_done=%b",
                                 $realtime, out_byte, run_last, file_done);
                    mismatches++;
                end
                else
                begin
                    want = framed_due.pop_front();
                    if (out_byte !== want.value || run_last !== want.last ||
                        file_done !== want.done)
                    begin
                        if (mismatches < 10)
                            $display("%0t: beat mismatch expected %h/%b/%b got %h/%b/%b",
                                     $realtime, want.value, want.last, want.done,
                                     out_byte, run_last, file_done);
                        mismatches++;
                    end
                end
            end
            if (stall_armed && !stall_taken)
            begin
                stall_left = 400;
                stall_taken = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [16:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CMD_FORMAT:   fmt_cmd = value[0];
            CFG_BLOCK_SIZE:   blk_size = value[8:0];
            CFG_LOAD_ADDRESS: base_addr = value[15:0];
            CFG_TOTAL_LENGTH: file_len = value;
            default:          ;
        endcase
    endtask

    task automatic set_framing(input int cmd, input int bs, input int addr, input int tot);
        write_reg(CFG_CMD_FORMAT, 17'(cmd));
        write_reg(CFG_BLOCK_SIZE, 17'(bs));
        write_reg(CFG_LOAD_ADDRESS, 17'(addr));
        write_reg(CFG_TOTAL_LENGTH, 17'(tot));
    endtask

    // Queues program bytes and waits until every framed beat has been popped.
    task automatic send_bytes(input int count, input bit corners);
        logic [7:0] corner_vals[4];
        corner_vals = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        for (int i = 0; i < count; i++)
            program_bytes.push_back(corners ? corner_vals[i % 4] : 8'($urandom_range(255)));
        items_sent += count;
        while (program_bytes.size() != 0 || framed_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int pick;
        int bs_sel;
        int addr_sel;
        int tot;
        int count;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset framing first, then cases that cross block and file ends.
        send_bytes(1, 1'b1);
        set_framing(1, 10, 16'hFFFF, 12);          // address wraps, full then partial block
        send_bytes(12, 1'b1);
        set_framing(0, 0, 16'h1234, 0);            // size below range, length zero
        send_bytes(1, 1'b1);
        set_framing(0, 511, 16'h8000, 2);          // size above range
        send_bytes(2, 1'b1);
        set_framing(0, 10, 16'h00FF, 10);          // file ends on a block boundary
        send_bytes(10, 1'b1);
        set_framing(1, 256, 16'h0000, 65536);      // largest length, file left open
        send_bytes(1, 1'b1);

        // Largest tape block plus one byte; the receiver holds off while the sender offers.
        set_framing(0, 256, $urandom_range(65535), 257);
        stall_armed = 1'b1;
        send_bytes(128, 1'b0);
        send_bytes(129, 1'b0);

        send_idle_pct = 71;
        recv_idle_pct = 11;
        while (items_sent < 440)
        begin
            if (items_sent >= 380)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(11);
            bs_sel = (pick == 0) ? $urandom_range(9) :
                     (pick == 1) ? $urandom_range(511, 257) : $urandom_range(24, 10);
            addr_sel = ($urandom_range(3) == 0) ? 65535 - $urandom_range(24) :
                       $urandom_range(65535);
            case (pick)
                2:       tot = 0;
                3:       tot = 65536;
                4:       tot = $urandom_range(131071, 65537);
                default: tot = $urandom_range(30, 1);
            endcase
            // Mostly whole files; some phases stop mid-file so the next settings land mid-file.
            if (tot == 0)
                count = 1;
            else if (tot > 30 || $urandom_range(5) == 0)
                count = $urandom_range(20, 1);
            else
                count = tot;
            set_framing($urandom_range(1), bs_sel, addr_sel, tot);
            send_bytes(count, 1'b0);
        end

        while (framed_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && framed_due.size() == 0)
            $display("load_block_framer_top verification clean");
        else
            $display("load_block_framer_top verification failed");
        $finish;
    end

endmodule
